// ===== rtl/acb_pkg.sv =====
package acb_pkg;

    // Default for the POSITION_WIDTH parameter of the top level
    localparam int POSITION_WIDTH_DEF = 32;

    localparam int SAMPLE_W  = 16;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 2;
    // Quotient bits of the blend divider; one chain cell per bit
    localparam int QUO_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FADE_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_END   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_16BIT = 2'd2;

    typedef enum logic [1:0] {
        SEL_SECOND,
        SEL_FIRST,
        SEL_BLEND
    } t_sel;

    typedef struct packed {
        logic [CFG_W-1:0]           sample_position;
        logic signed [SAMPLE_W-1:0] first_sample;
        logic signed [SAMPLE_W-1:0] second_sample;
        logic                       burst_last;
    } t_in_beat;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mixed_sample;
        logic                       burst_last_out;
    } t_out_beat;

    // Per-sample side data that rides along with the divider chain
    typedef struct packed {
        t_sel                sel;
        logic                neg;
        logic [SAMPLE_W-1:0] first;
        logic [SAMPLE_W-1:0] second;
        logic                last;
        logic                mode16;
    } t_side;

endpackage

// ===== rtl/acb_prep.sv =====
module acb_prep import acb_pkg::*; #(
    parameter int SPAN_W = CFG_W
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  t_in_beat                i_data,
    input  logic                    i_mode16,
    input  logic [SPAN_W-1:0]       i_fade_end,
    input  logic signed [SPAN_W:0]  i_span,
    output logic                    o_valid,
    output logic [QUO_W+SPAN_W-1:0] o_num,
    output t_side                   o_side
);

    localparam int NUM_W = QUO_W + SPAN_W;

    logic                     r1_valid;
    logic [QUO_W-1:0]         r1_mag;
    logic [SPAN_W-1:0]        r1_weight;
    logic [SPAN_W-2:0]        r1_half;
    t_side                    r1_side;

    logic                     r2_valid;
    logic [NUM_W-1:0]         r2_num;
    t_side                    r2_side;

    logic [SPAN_W-1:0]        pos_e;
    logic signed [SPAN_W:0]   weight;
    logic [SAMPLE_W:0]        ax;
    logic [SAMPLE_W:0]        bx;
    logic [SAMPLE_W:0]        diff;
    logic [SAMPLE_W:0]        diff_neg;
    t_side                    n1_side;
    logic [QUO_W-1:0]         n1_mag;
    logic [NUM_W-1:0]         n2_num;

    // Decode samples and classify the position against the fade window
    always_comb begin
        pos_e  = i_data.sample_position[SPAN_W-1:0];
        weight = $signed({1'b0, i_fade_end}) - $signed({1'b0, pos_e});
        if (i_mode16) begin
            ax = {i_data.first_sample[SAMPLE_W-1], i_data.first_sample};
            bx = {i_data.second_sample[SAMPLE_W-1], i_data.second_sample};
        end else begin
            ax = {{(SAMPLE_W-7){1'b0}}, i_data.first_sample[7:0]};
            bx = {{(SAMPLE_W-7){1'b0}}, i_data.second_sample[7:0]};
        end
        diff     = ax - bx;
        diff_neg = (~diff) + {{SAMPLE_W{1'b0}}, 1'b1};
        n1_mag   = diff[SAMPLE_W] ? diff_neg[QUO_W-1:0] : diff[QUO_W-1:0];

        n1_side.neg    = diff[SAMPLE_W];
        n1_side.first  = ax[SAMPLE_W-1:0];
        n1_side.second = bx[SAMPLE_W-1:0];
        n1_side.last   = i_data.burst_last;
        n1_side.mode16 = i_mode16;
        if (weight <= $signed({(SPAN_W+1){1'b0}})) begin
            n1_side.sel = SEL_SECOND;
        end else if (weight < i_span) begin
            n1_side.sel = SEL_BLEND;
        end else begin
            n1_side.sel = SEL_FIRST;
        end
    end

    // Rounded numerator: magnitude times weight plus half the span
    always_comb begin
        n2_num = NUM_W'(r1_mag) * NUM_W'(r1_weight) + NUM_W'(r1_half);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mag    <= n1_mag;
            r1_weight <= weight[SPAN_W-1:0];
            r1_half   <= i_span[SPAN_W-1:1];
            r1_side   <= n1_side;
            r2_num    <= n2_num;
            r2_side   <= r1_side;
        end
    end

    assign o_valid = r2_valid;
    assign o_num   = r2_num;
    assign o_side  = r2_side;

endmodule

// ===== rtl/acb_div_cell.sv =====
module acb_div_cell import acb_pkg::*; #(
    parameter int SPAN_W = CFG_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [SPAN_W-1:0] i_span,
    input  logic              i_valid,
    input  logic [SPAN_W-1:0] i_rem,
    input  logic [QUO_W-1:0]  i_lo,
    input  logic [QUO_W-1:0]  i_quo,
    input  t_side             i_side,
    output logic              o_valid,
    output logic [SPAN_W-1:0] o_rem,
    output logic [QUO_W-1:0]  o_lo,
    output logic [QUO_W-1:0]  o_quo,
    output t_side             o_side
);

    logic              r_valid;
    logic [SPAN_W-1:0] r_rem;
    logic [QUO_W-1:0]  r_lo;
    logic [QUO_W-1:0]  r_quo;
    t_side             r_side;

    logic [SPAN_W:0]   trial;
    logic [SPAN_W:0]   diff;
    logic              take;
    logic [SPAN_W-1:0] n_rem;
    logic [QUO_W-1:0]  n_lo;
    logic [QUO_W-1:0]  n_quo;

    // One restoring step: shift in the next numerator bit, subtract if it fits
    always_comb begin
        trial = {i_rem, i_lo[QUO_W-1]};
        diff  = trial - {1'b0, i_span};
        take  = (trial >= {1'b0, i_span});
        n_rem = take ? diff[SPAN_W-1:0] : trial[SPAN_W-1:0];
        n_lo  = {i_lo[QUO_W-2:0], 1'b0};
        n_quo = {i_quo[QUO_W-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_lo   <= n_lo;
            r_quo  <= n_quo;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_lo    = r_lo;
    assign o_quo   = r_quo;
    assign o_side  = r_side;

endmodule

// ===== rtl/audio_crossfade_blend_top.sv =====
// Linear audio cross-fade from clip A (first_sample) to clip B (second_sample).
// Input channel: i_valid / o_ready carry one beat holding a sample of each
// clip, its sample-frame position and an end-of-block mark. Output channel:
// o_valid / i_ready carry the blended sample and the copied mark, one result
// beat per input beat, in order.
// Configuration: write fade start, fade end and the 16-bit mode flag through
// i_cfg_we / i_cfg_index / i_cfg_data while no beat is in flight.
// Throughput: one beat per cycle while the chain is not stalled. Path: the
// beat lands in the decode stage at the accepting edge, then passes the
// multiply stage, one divider cell per quotient bit (16) and the output
// register, which drives o_valid.
// Reset: all stages empty, fade start and end at zero, 16-bit mode on.
// Stall: when the output register is full and i_ready is low, the whole
// chain holds and o_ready drops; nothing is lost or repeated.
module audio_crossfade_blend_top import acb_pkg::*; #(
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_in_beat             i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_out_beat            o_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // Positions are masked to POSITION_WIDTH, but never exceed the field width
    localparam int SPAN_W = (POSITION_WIDTH < CFG_W) ? POSITION_WIDTH : CFG_W;
    localparam int NUM_W  = QUO_W + SPAN_W;

    logic [CFG_W-1:0]       r_fade_start;
    logic [CFG_W-1:0]       r_fade_end;
    logic                   r_mode16;

    logic                   r_out_valid;
    t_out_beat              r_out;

    logic                   en;
    logic [SPAN_W-1:0]      fade_end_e;
    logic [SPAN_W-1:0]      fade_start_e;
    logic signed [SPAN_W:0] span;

    logic                   prep_valid;
    logic [NUM_W-1:0]       prep_num;
    t_side                  prep_side;

    // Chain taps: index 0 is the chain input, QUO_W the last cell's output
    logic                   c_valid [0:QUO_W];
    logic [SPAN_W-1:0]      c_rem   [0:QUO_W];
    logic [QUO_W-1:0]       c_lo    [0:QUO_W];
    logic [QUO_W-1:0]       c_quo   [0:QUO_W];
    t_side                  c_side  [0:QUO_W];

    logic [SAMPLE_W-1:0]    blend;
    logic [SAMPLE_W-1:0]    mixed;
    t_out_beat              n_out;

    // Advance everything whenever the output register can take a beat
    assign en      = !r_out_valid || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_start <= '0;
            r_fade_end   <= '0;
            r_mode16     <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FADE_START: r_fade_start <= i_cfg_data;
                CFG_FADE_END:   r_fade_end   <= i_cfg_data;
                CFG_MODE_16BIT: r_mode16     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Span feeds decode, cells; config changes only with chain empty, user's job
    assign fade_end_e   = r_fade_end[SPAN_W-1:0];
    assign fade_start_e = r_fade_start[SPAN_W-1:0];
    assign span         = $signed({1'b0, fade_end_e}) - $signed({1'b0, fade_start_e});

    acb_prep #(
        .SPAN_W (SPAN_W)
    ) u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_valid),
        .i_data     (i_data),
        .i_mode16   (r_mode16),
        .i_fade_end (fade_end_e),
        .i_span     (span),
        .o_valid    (prep_valid),
        .o_num      (prep_num),
        .o_side     (prep_side)
    );

    // Upper numerator bits seed the remainder (below span for blend beats);
    // the low QUO_W bits shift into the cells one per stage.
    assign c_valid[0] = prep_valid;
    assign c_rem[0]   = prep_num[NUM_W-1:QUO_W];
    assign c_lo[0]    = prep_num[QUO_W-1:0];
    assign c_quo[0]   = '0;
    assign c_side[0]  = prep_side;

    for (genvar g = 0; g < QUO_W; g++) begin : g_cell
        acb_div_cell #(
            .SPAN_W (SPAN_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_span  (span[SPAN_W-1:0]),
            .i_valid (c_valid[g]),
            .i_rem   (c_rem[g]),
            .i_lo    (c_lo[g]),
            .i_quo   (c_quo[g]),
            .i_side  (c_side[g]),
            .o_valid (c_valid[g+1]),
            .o_rem   (c_rem[g+1]),
            .o_lo    (c_lo[g+1]),
            .o_quo   (c_quo[g+1]),
            .o_side  (c_side[g+1])
        );
    end

    // Apply the sign of A minus B to the rounded quotient and pick the result;
    // wrap to the sample width, and clear the upper byte in 8-bit mode.
    always_comb begin
        if (c_side[QUO_W].neg) begin
            blend = c_side[QUO_W].second - c_quo[QUO_W];
        end else begin
            blend = c_side[QUO_W].second + c_quo[QUO_W];
        end
        case (c_side[QUO_W].sel)
            SEL_FIRST:  mixed = c_side[QUO_W].first;
            SEL_BLEND:  mixed = blend;
            default:    mixed = c_side[QUO_W].second;
        endcase
        if (c_side[QUO_W].mode16) begin
            n_out.mixed_sample = mixed;
        end else begin
            n_out.mixed_sample = {8'h00, mixed[7:0]};
        end
        n_out.burst_last_out = c_side[QUO_W].last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= c_valid[QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
